[rtl/core/gfau_pkg.sv]
// Shared types, constants and helpers of the GF(2^m) arithmetic unit.
package gfau_pkg;

    // Largest supported field degree; symbols and tables are sized from it
    localparam int MAX_DEGREE = 8;
    localparam int MIN_DEGREE = 2;

    localparam int SYM_W      = MAX_DEGREE;
    localparam int TBL_DEPTH  = 1 << SYM_W;
    localparam int M_W        = $clog2(MAX_DEGREE + 1);
    // Reduction input width: the exponent field or a log product
    localparam int RED_W      = (2 * SYM_W > 16) ? 2 * SYM_W : 16;
    // Sum of up to RED_W/2 digits of at most SYM_W bits each
    localparam int SUM_W      = SYM_W + 5;
    localparam int BYTE_EXT_W = (SYM_W > 8) ? SYM_W : 8;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam logic REG_FIELD_DEGREE = 1'b0;
    localparam logic REG_POLY_TAPS    = 1'b1;
    localparam logic [3:0] FIELD_DEGREE_RST = 4'd8;
    localparam logic [7:0] POLY_TAPS_RST    = 8'd29;

    // Request types
    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_MUL     = 3'd1,
        OP_DIV     = 3'd2,
        OP_POW     = 3'd3,
        OP_INV     = 3'd4,
        OP_LOG     = 3'd5,
        OP_ANTILOG = 3'd6
    } op_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  operand_a;
        logic [7:0]  operand_b;
        logic [15:0] exponent;
    } req_t;

    typedef struct packed {
        logic [7:0] result;
        logic       error;
    } rsp_t;

    // Effective field parameters derived from the configuration registers
    typedef struct packed {
        logic [M_W-1:0]   m;
        logic [SYM_W-1:0] n;
        logic [SYM_W-1:0] top;
        logic [SYM_W-1:0] taps;
    } cfg_t;

    // Table write port driven by the builder
    typedef struct packed {
        logic             log_we;
        logic [SYM_W-1:0] log_addr;
        logic [SYM_W-1:0] log_data;
        logic             alog_we;
        logic [SYM_W-1:0] alog_addr;
        logic [SYM_W-1:0] alog_data;
    } tbl_wr_t;

    // Table read port driven by the datapath
    typedef struct packed {
        logic             re;
        logic [SYM_W-1:0] log_a_addr;
        logic [SYM_W-1:0] log_b_addr;
        logic [SYM_W-1:0] alog_addr;
    } tbl_rd_t;

    // Byte field to symbol width
    function automatic logic [SYM_W-1:0] to_sym(input logic [7:0] x);
        logic [BYTE_EXT_W-1:0] ext;
        ext = BYTE_EXT_W'(x);
        return SYM_W'(ext);
    endfunction

    // Symbol to byte field
    function automatic logic [7:0] to_byte(input logic [SYM_W-1:0] x);
        logic [BYTE_EXT_W-1:0] ext;
        ext = BYTE_EXT_W'(x);
        return 8'(ext);
    endfunction

endpackage

[rtl/core/gfau_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gfau_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/gfau_table_builder.sv]
// Sequencer that clears the log table and fills both tables by an LFSR walk.
module gfau_table_builder (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  gfau_pkg::cfg_t  cfg,
    output logic            busy,
    output gfau_pkg::tbl_wr_t wr
);
    import gfau_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_WALK  = 3'b010,
        ST_RUN   = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [SYM_W-1:0] cnt_reg, cnt_next;
    logic [SYM_W-1:0] v_reg, v_next;
    logic [SYM_W-1:0] v_step;

    // Next LFSR value: shift left, fold the top bit back through the taps
    always_comb
    begin
        if ((v_reg & cfg.top) != '0)
        begin
            v_step = cfg.taps ^ (((v_reg ^ cfg.top) << 1) & cfg.n);
        end
        else
        begin
            v_step = (v_reg << 1) & cfg.n;
        end
    end

    // Sequencer and table writes
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        v_next     = v_reg;
        wr         = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr.log_we   = 1'b1;
                wr.log_addr = cnt_reg;
                if (cnt_reg == '1)
                begin
                    state_next = ST_WALK;
                    cnt_next   = '0;
                    v_next     = SYM_W'(1);
                end
                else
                begin
                    cnt_next = cnt_reg + SYM_W'(1);
                end
            end
            ST_WALK:
            begin
                wr.alog_we   = 1'b1;
                wr.alog_addr = cnt_reg;
                wr.alog_data = v_reg;
                wr.log_we    = 1'b1;
                wr.log_addr  = v_reg;
                wr.log_data  = cnt_reg;
                v_next       = v_step;
                if (cnt_reg == cfg.n - SYM_W'(1))
                begin
                    state_next = ST_RUN;
                end
                else
                begin
                    cnt_next = cnt_reg + SYM_W'(1);
                end
            end
            ST_RUN:
            begin
            end
            default:
            begin
                state_next = ST_CLEAR;
                cnt_next   = '0;
            end
        endcase
        // a configuration write restarts the build
        if (start)
        begin
            state_next = ST_CLEAR;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            v_reg     <= SYM_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            v_reg     <= v_next;
        end
    end

    assign busy = (state_reg != ST_RUN);

endmodule

[rtl/core/gfau_datapath.sv]
// Request pipeline: log lookups, exponent reduction, antilog lookup, output skid.
module gfau_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  gfau_pkg::cfg_t     cfg,
    input  logic               busy,
    input  logic               req_valid,
    output logic               req_ready,
    input  gfau_pkg::req_t     req_data,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output gfau_pkg::rsp_t     rsp_data,
    output gfau_pkg::tbl_rd_t  rd,
    input  logic [gfau_pkg::SYM_W-1:0] log_a_q,
    input  logic [gfau_pkg::SYM_W-1:0] log_b_q,
    input  logic [gfau_pkg::SYM_W-1:0] alog_q
);
    import gfau_pkg::*;

    localparam int MAX_DIGITS = RED_W / MIN_DEGREE;

    typedef struct packed {
        logic             valid;
        logic [2:0]       op;
        logic [SYM_W-1:0] a;
        logic [SYM_W-1:0] b;
        logic [SUM_W-1:0] esum;
    } s1_t;

    typedef struct packed {
        logic             valid;
        logic [2:0]       op;
        logic [SYM_W-1:0] a;
        logic [SYM_W-1:0] b;
        logic [SYM_W-1:0] la;
        logic [SYM_W-1:0] lb;
        logic [SYM_W-1:0] er;
    } s2_t;

    typedef struct packed {
        logic               valid;
        logic               pow;
        logic [2*SYM_W-1:0] prod;
        logic [SYM_W-1:0]   idx;
        logic [SYM_W-1:0]   direct;
        logic               use_tbl;
        logic               err;
    } s3_t;

    typedef struct packed {
        logic             valid;
        logic             pow;
        logic [SUM_W-1:0] psum;
        logic [SYM_W-1:0] idx;
        logic [SYM_W-1:0] direct;
        logic             use_tbl;
        logic             err;
    } s4_t;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] direct;
        logic             use_tbl;
        logic             err;
    } s5_t;

    // Sum of the m-bit digits: congruent to x modulo 2^m-1
    function automatic logic [SUM_W-1:0] digit_sum(input logic [RED_W-1:0] x,
                                                   input logic [M_W-1:0]   m);
        logic [SUM_W-1:0] acc;
        logic [RED_W-1:0] mask;
        acc  = '0;
        mask = (RED_W'(1) << m) - RED_W'(1);
        for (int k = 0; k < MAX_DIGITS; k++)
        begin
            acc = acc + SUM_W'((x >> (k * int'(m))) & mask);
        end
        return acc;
    endfunction

    // End-around folds and a final correction bring a digit sum below n
    function automatic logic [SYM_W-1:0] fold(input logic [SUM_W-1:0] s,
                                              input logic [M_W-1:0]   m,
                                              input logic [SYM_W-1:0] n);
        logic [SUM_W-1:0] x;
        x = s;
        for (int j = 0; j < 4; j++)
        begin
            x = (x & SUM_W'(n)) + (x >> m);
        end
        if (x >= SUM_W'(n))
        begin
            x = x - SUM_W'(n);
        end
        return SYM_W'(x);
    endfunction

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;

    rsp_t out_reg, out_next;
    rsp_t skid_reg, skid_next;
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;

    logic             adv;
    logic             accept;
    logic [SYM_W-1:0] in_a;
    logic [SYM_W-1:0] in_b;
    logic [SYM_W:0]   sum_ab;
    logic [SYM_W-1:0] sub_ab;
    logic             prod_valid;
    rsp_t             prod_rsp;

    // The whole pipeline moves unless the skid stage is holding a result
    assign adv       = !skid_valid_reg;
    assign req_ready = adv && !busy;
    assign accept    = req_valid && req_ready;

    assign in_a = to_sym(req_data.operand_a) & cfg.n;
    assign in_b = to_sym(req_data.operand_b) & cfg.n;

    // Table reads: logs at accept, antilog out of stage 4
    always_comb
    begin
        rd.re         = adv;
        rd.log_a_addr = in_a;
        rd.log_b_addr = in_b;
        rd.alog_addr  = s4_reg.pow ? fold(s4_reg.psum, cfg.m, cfg.n) : s4_reg.idx;
    end

    // Stage 1: operands, exponent digit sum
    always_comb
    begin
        s1_next.valid = accept;
        s1_next.op    = req_data.req_type;
        s1_next.a     = in_a;
        s1_next.b     = in_b;
        s1_next.esum  = digit_sum(RED_W'(req_data.exponent), cfg.m);
    end

    // Stage 2: log values arrive, exponent reduced modulo n
    always_comb
    begin
        s2_next.valid = s1_reg.valid;
        s2_next.op    = s1_reg.op;
        s2_next.a     = s1_reg.a;
        s2_next.b     = s1_reg.b;
        s2_next.la    = log_a_q;
        s2_next.lb    = log_b_q;
        s2_next.er    = fold(s1_reg.esum, cfg.m, cfg.n);
    end

    // Stage 3: per-request index or direct result, power product
    assign sum_ab = {1'b0, s2_reg.la} + {1'b0, s2_reg.lb};
    assign sub_ab = (s2_reg.la >= s2_reg.lb) ? (s2_reg.la - s2_reg.lb)
                                             : (s2_reg.la + cfg.n - s2_reg.lb);

    always_comb
    begin
        s3_next       = '0;
        s3_next.valid = s2_reg.valid;
        s3_next.prod  = (2*SYM_W)'(s2_reg.la) * (2*SYM_W)'(s2_reg.er);
        unique case (s2_reg.op)
            OP_ADD:
            begin
                s3_next.direct = s2_reg.a ^ s2_reg.b;
            end
            OP_MUL:
            begin
                if (s2_reg.a != '0 && s2_reg.b != '0)
                begin
                    s3_next.use_tbl = 1'b1;
                    if (sum_ab >= {1'b0, cfg.n})
                    begin
                        s3_next.idx = SYM_W'(sum_ab - {1'b0, cfg.n});
                    end
                    else
                    begin
                        s3_next.idx = SYM_W'(sum_ab);
                    end
                end
            end
            OP_DIV:
            begin
                if (s2_reg.b == '0)
                begin
                    s3_next.err = 1'b1;
                end
                else if (s2_reg.a != '0)
                begin
                    s3_next.use_tbl = 1'b1;
                    s3_next.idx     = sub_ab;
                end
            end
            OP_POW:
            begin
                if (s2_reg.a != '0)
                begin
                    s3_next.use_tbl = 1'b1;
                    s3_next.pow     = 1'b1;
                end
            end
            OP_INV:
            begin
                if (s2_reg.a == '0)
                begin
                    s3_next.err = 1'b1;
                end
                else
                begin
                    s3_next.use_tbl = 1'b1;
                    s3_next.idx     = (s2_reg.la == '0) ? '0 : (cfg.n - s2_reg.la);
                end
            end
            OP_LOG:
            begin
                if (s2_reg.a == '0)
                begin
                    s3_next.err = 1'b1;
                end
                else
                begin
                    s3_next.direct = s2_reg.la;
                end
            end
            OP_ANTILOG:
            begin
                s3_next.use_tbl = 1'b1;
                s3_next.idx     = (s2_reg.a == cfg.n) ? '0 : s2_reg.a;
            end
            default:
            begin
            end
        endcase
    end

    // Stage 4: digit sum of the power product
    always_comb
    begin
        s4_next.valid   = s3_reg.valid;
        s4_next.pow     = s3_reg.pow;
        s4_next.psum    = digit_sum(RED_W'(s3_reg.prod), cfg.m);
        s4_next.idx     = s3_reg.idx;
        s4_next.direct  = s3_reg.direct;
        s4_next.use_tbl = s3_reg.use_tbl;
        s4_next.err     = s3_reg.err;
    end

    // Stage 5: antilog value arrives
    always_comb
    begin
        s5_next.valid   = s4_reg.valid;
        s5_next.direct  = s4_reg.direct;
        s5_next.use_tbl = s4_reg.use_tbl;
        s5_next.err     = s4_reg.err;
    end

    assign prod_valid      = s5_reg.valid && adv;
    assign prod_rsp.result = to_byte(s5_reg.use_tbl ? alog_q : s5_reg.direct);
    assign prod_rsp.error  = s5_reg.err;

    // Output register with one skid entry
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (rsp_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = prod_rsp;
                out_valid_next = prod_valid;
            end
        end
        else if (prod_valid)
        begin
            skid_next       = prod_rsp;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg         <= '0;
            s2_reg         <= '0;
            s3_reg         <= '0;
            s4_reg         <= '0;
            s5_reg         <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s1_reg <= s1_next;
                s2_reg <= s2_next;
                s3_reg <= s3_next;
                s4_reg <= s4_next;
                s5_reg <= s5_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

[rtl/core/galois_field_arithmetic_unit.sv]
// Top level of the GF(2^m) arithmetic unit: register port, table RAMs, pipeline.
//
// Requests enter on req_valid/req_ready/req_data and each gives one response
// on rsp_valid/rsp_ready/rsp_data, in request order. Request types: add/sub,
// mul, div, power, inverse, log and antilog over GF(2^m).
// Throughput is one request per cycle while no rebuild runs and the skid entry is empty.
// Before it is offered, a response passes two log-table RAM reads, the exponent
// and product reductions modulo 2^m-1, and one antilog-table RAM read.
// The APB port holds field_degree (address 0) and poly_taps (address 4).
// After reset and after every register write the tables are rebuilt:
// a clearing pass over all 2^MAX_DEGREE (256) log-table entries followed
// by an LFSR walk over 2^m-1 entries. req_ready stays low during the rebuild.
// When the receiver stalls, a one-entry skid stage behind the output register
// catches the last result in flight and then the whole pipeline holds;
// req_ready also drops while that skid entry is full.
module galois_field_arithmetic_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gfau_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  gfau_pkg::req_t                    req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output gfau_pkg::rsp_t                    rsp_data
);
    import gfau_pkg::*;

    logic [3:0]       field_degree_reg, field_degree_next;
    logic [7:0]       poly_taps_reg, poly_taps_next;
    logic             cfg_wr;
    logic [M_W-1:0]   m_eff;
    cfg_t             cfg;
    logic             build_busy;
    tbl_wr_t          tbl_wr;
    tbl_rd_t          tbl_rd;
    logic [SYM_W-1:0] log_a_q;
    logic [SYM_W-1:0] log_b_q;
    logic [SYM_W-1:0] alog_q;

    // Register writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        field_degree_next = field_degree_reg;
        poly_taps_next    = poly_taps_reg;
        if (cfg_wr)
        begin
            if (paddr[2] == REG_POLY_TAPS)
            begin
                poly_taps_next = pwdata[7:0];
            end
            else
            begin
                field_degree_next = pwdata[3:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_degree_reg <= FIELD_DEGREE_RST;
            poly_taps_reg    <= POLY_TAPS_RST;
        end
        else
        begin
            field_degree_reg <= field_degree_next;
            poly_taps_reg    <= poly_taps_next;
        end
    end

    // Register reads
    assign prdata = (paddr[2] == REG_FIELD_DEGREE) ? 32'(field_degree_reg)
                                                   : 32'(poly_taps_reg);

    // Effective degree clamped to the supported range, and derived masks
    always_comb
    begin
        if (int'(field_degree_reg) < MIN_DEGREE)
        begin
            m_eff = M_W'(MIN_DEGREE);
        end
        else if (int'(field_degree_reg) > MAX_DEGREE)
        begin
            m_eff = M_W'(MAX_DEGREE);
        end
        else
        begin
            m_eff = M_W'(field_degree_reg);
        end
        cfg.m    = m_eff;
        cfg.n    = SYM_W'((32'd1 << m_eff) - 32'd1);
        cfg.top  = SYM_W'(32'd1 << (m_eff - M_W'(1)));
        cfg.taps = to_sym(poly_taps_reg) & cfg.n;
    end

    gfau_table_builder u_builder (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_wr),
        .cfg   (cfg),
        .busy  (build_busy),
        .wr    (tbl_wr)
    );

    // Log table, one copy per operand read port
    gfau_ram #(.WIDTH(SYM_W), .DEPTH(TBL_DEPTH)) u_log_a_ram (
        .clk   (clk),
        .we    (tbl_wr.log_we),
        .waddr (tbl_wr.log_addr),
        .wdata (tbl_wr.log_data),
        .re    (tbl_rd.re),
        .raddr (tbl_rd.log_a_addr),
        .rdata (log_a_q)
    );

    gfau_ram #(.WIDTH(SYM_W), .DEPTH(TBL_DEPTH)) u_log_b_ram (
        .clk   (clk),
        .we    (tbl_wr.log_we),
        .waddr (tbl_wr.log_addr),
        .wdata (tbl_wr.log_data),
        .re    (tbl_rd.re),
        .raddr (tbl_rd.log_b_addr),
        .rdata (log_b_q)
    );

    // Antilog table
    gfau_ram #(.WIDTH(SYM_W), .DEPTH(TBL_DEPTH)) u_alog_ram (
        .clk   (clk),
        .we    (tbl_wr.alog_we),
        .waddr (tbl_wr.alog_addr),
        .wdata (tbl_wr.alog_data),
        .re    (tbl_rd.re),
        .raddr (tbl_rd.alog_addr),
        .rdata (alog_q)
    );

    gfau_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .busy      (build_busy),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .rd        (tbl_rd),
        .log_a_q   (log_a_q),
        .log_b_q   (log_b_q),
        .alog_q    (alog_q)
    );

endmodule

[tb/galois_field_arithmetic_unit_tb.sv]
// Self-checking testbench for the GF(2^m) arithmetic unit with a table-based result predictor.
module galois_field_arithmetic_unit_tb;

    import gfau_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int PHASE_ITEMS   = 137;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int PIPE_SETTLE   = 8;
    localparam int WATCHDOG_TIME = 5_000_000;

    // Request type code that the block does not define
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    // Register byte addresses
    localparam logic [APB_ADDR_W-1:0] ADDR_FIELD_DEGREE = {REG_FIELD_DEGREE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_POLY_TAPS    = {REG_POLY_TAPS, 2'b00};

    // Expected GF results: shadow copy of the configuration and tables, plus
    // the queue of results still owed by the block
    class gf_result_scoreboard;
        bit [3:0]    degree_reg;
        bit [7:0]    taps_reg;
        int unsigned field_n;
        bit [7:0]    alpha_pow[TBL_DEPTH];
        bit [7:0]    alpha_log[TBL_DEPTH];
        rsp_t        owed_results[$];
        int          failures;

        function new();
            degree_reg = FIELD_DEGREE_RST;
            taps_reg   = POLY_TAPS_RST;
            failures   = 0;
            rebuild_tables();
        endfunction

        // LFSR walk from alpha^0 = 1; non-primitive taps overwrite log entries
        function void rebuild_tables();
            int unsigned m, top, taps, v;
            m = degree_reg;
            if (m < MIN_DEGREE) m = MIN_DEGREE;
            if (m > MAX_DEGREE) m = MAX_DEGREE;
            field_n = (1 << m) - 1;
            top     = 1 << (m - 1);
            taps    = taps_reg & field_n;
            for (int i = 0; i < TBL_DEPTH; i++)
            begin
                alpha_pow[i] = '0;
                alpha_log[i] = '0;
            end
            v = 1;
            for (int unsigned i = 0; i < field_n; i++)
            begin
                alpha_pow[i]             = v[7:0];
                alpha_log[v & field_n]   = i[7:0];
                if ((v & top) != 0)
                    v = taps ^ (((v ^ top) << 1) & field_n);
                else
                    v = (v << 1) & field_n;
            end
        endfunction

        function void write_config(logic [APB_ADDR_W-1:0] addr, logic [31:0] value);
            if (addr == ADDR_FIELD_DEGREE)
                degree_reg = value[3:0];
            else if (addr == ADDR_POLY_TAPS)
                taps_reg = value[7:0];
            else
                return;
            rebuild_tables();
        endfunction

        function rsp_t gf_evaluate(req_t r);
            int unsigned n, a, b, e, la, lb, res;
            rsp_t        rsp;
            n   = field_n;
            a   = r.operand_a & n;
            b   = r.operand_b & n;
            e   = r.exponent;
            res = 0;
            rsp.error = 1'b0;
            case (r.req_type)
                OP_ADD: res = a ^ b;
                OP_MUL:
                    if (a != 0 && b != 0)
                    begin
                        la  = alpha_log[a];
                        lb  = alpha_log[b];
                        res = alpha_pow[(la + lb) % n];
                    end
                OP_DIV:
                    if (b == 0)
                        rsp.error = 1'b1;
                    else if (a != 0)
                    begin
                        la  = alpha_log[a];
                        lb  = alpha_log[b];
                        res = alpha_pow[(la + n - lb) % n];
                    end
                OP_POW:
                    if (a != 0)
                    begin
                        la  = alpha_log[a];
                        res = alpha_pow[(la * (e % n)) % n];
                    end
                OP_INV:
                    if (a == 0)
                        rsp.error = 1'b1;
                    else
                    begin
                        la  = alpha_log[a];
                        res = alpha_pow[(n - la) % n];
                    end
                OP_LOG:
                    if (a == 0)
                        rsp.error = 1'b1;
                    else
                        res = alpha_log[a];
                OP_ANTILOG: res = alpha_pow[a % n];
                default: res = 0;
            endcase
            rsp.result = res[7:0];
            return rsp;
        endfunction

        function void note_request(req_t r);
            owed_results.push_back(gf_evaluate(r));
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (owed_results.size() == 0)
            begin
                $error("response with no request outstanding: result %0h error %0b",
                       got.result, got.error);
                failures++;
                return;
            end
            want = owed_results.pop_front();
            if (got.result !== want.result)
            begin
                $error("result mismatch: expected %0h actual %0h", want.result, got.result);
                failures++;
            end
            if (got.error !== want.error)
            begin
                $error("error mismatch: expected %0b actual %0b", want.error, got.error);
                failures++;
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function void drop_leftovers();
            $error("%0d responses never arrived", owed_results.size());
            failures += owed_results.size();
            owed_results.delete();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req_data  = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp_data;

    gf_result_scoreboard scoreboard = new();
    bit          idle_on = 1'b1;
    int          stall_left = 0;

    galois_field_arithmetic_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always #CLK_HALF clk = ~clk;

    // Receiver: random stall bursts while idling is enabled
    always @(negedge clk)
    begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 11);
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    // Response monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            scoreboard.check_result(rsp_data);
    end

    // Hang guard
    initial
    begin
        #(WATCHDOG_TIME);
        $display("galois_field_arithmetic_unit test failed");
        $finish;
    end

    // Send one request after an optional gap; valid stays high until accepted
    task automatic send_request(input req_t r, input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (!req_ready);
        scoreboard.note_request(r);
    endtask

    task automatic send_op(input logic [2:0] code, input logic [7:0] a,
                           input logic [7:0] b, input logic [15:0] e);
        req_t r;
        r.req_type  = code;
        r.operand_a = a;
        r.operand_b = b;
        r.exponent  = e;
        send_request(r, 0);
    endtask

    // Wait for every owed response, let the pipeline settle, then for ready
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge clk);
        req_valid <= 1'b0;
        while (scoreboard.pending() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (scoreboard.pending() > 0)
            scoreboard.drop_leftovers();
        repeat (PIPE_SETTLE) @(negedge clk);
        while (!req_ready) @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        scoreboard.write_config(addr, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [7:0] pick_symbol(int unsigned n);
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return n[7:0];
            2: return 8'h01;
            3: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic req_t random_request(int unsigned n);
        req_t r;
        if ($urandom_range(0, 15) == 0)
            r.req_type = REQ_UNUSED;
        else
            r.req_type = 3'($urandom_range(OP_ADD, OP_ANTILOG));
        r.operand_a = pick_symbol(n);
        r.operand_b = pick_symbol(n);
        case ($urandom_range(0, 7))
            0: r.exponent = 16'h0000;
            1: r.exponent = 16'hFFFF;
            2: r.exponent = 16'(n * $urandom_range(1, 200));
            3: r.exponent = 16'($urandom_range(0, 2 * n));
            default: r.exponent = 16'($urandom_range(0, 65535));
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        if (idle_on && $urandom_range(0, 7) == 0)
            return $urandom_range(1, 11);
        return 0;
    endfunction

    // One field setting followed by a burst of random requests
    task automatic run_phase(input int unsigned degree, input int unsigned taps,
                             input bit idle, input bit hold_midway);
        apb_write(ADDR_FIELD_DEGREE, 32'(degree));
        apb_write(ADDR_POLY_TAPS, 32'(taps));
        idle_on = idle;
        for (int k = 0; k < PHASE_ITEMS; k++)
        begin
            if (hold_midway && k == PHASE_ITEMS / 2)
                settle();
            send_request(random_request(scoreboard.field_n), pick_gap());
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed corner cases at the reset field, GF(2^8) with taps 0x1D
        idle_on = 1'b0;
        send_op(OP_ADD, 8'hFF, 8'hFF, 16'h0000);
        send_op(OP_ADD, 8'h00, 8'hA5, 16'hFFFF);
        send_op(OP_MUL, 8'h00, 8'hFF, 16'h0000);
        send_op(OP_MUL, 8'hFF, 8'h00, 16'h0000);
        send_op(OP_MUL, 8'hFF, 8'hFF, 16'h0000);
        send_op(OP_MUL, 8'h02, 8'h80, 16'h0000);
        send_op(OP_DIV, 8'h37, 8'h00, 16'h0000);
        send_op(OP_DIV, 8'h00, 8'h00, 16'h0000);
        send_op(OP_DIV, 8'h00, 8'h09, 16'h0000);
        send_op(OP_DIV, 8'hFF, 8'h03, 16'h0000);
        send_op(OP_POW, 8'h00, 8'h00, 16'h0000);
        send_op(OP_POW, 8'h00, 8'h00, 16'hFFFF);
        send_op(OP_POW, 8'h02, 8'h00, 16'h0000);
        send_op(OP_POW, 8'h03, 8'h00, 16'hFFFF);
        send_op(OP_POW, 8'h02, 8'h00, 16'h00FF);
        send_op(OP_POW, 8'h05, 8'h00, 16'h0100);
        send_op(OP_INV, 8'h00, 8'h00, 16'h0000);
        send_op(OP_INV, 8'h01, 8'h00, 16'h0000);
        send_op(OP_INV, 8'hFF, 8'h00, 16'h0000);
        send_op(OP_LOG, 8'h00, 8'h00, 16'h0000);
        send_op(OP_LOG, 8'h01, 8'h00, 16'h0000);
        send_op(OP_LOG, 8'hFF, 8'h00, 16'h0000);
        send_op(OP_ANTILOG, 8'h00, 8'h00, 16'h0000);
        send_op(OP_ANTILOG, 8'hFF, 8'h00, 16'h0000);
        send_op(OP_ANTILOG, 8'hFE, 8'h00, 16'h0000);
        send_op(REQ_UNUSED, 8'hFF, 8'hFF, 16'hFFFF);

        // Field settings: smallest and largest degree, clamped degrees,
        // degenerate and non-primitive taps, random picks
        run_phase(2, 3, 1'b1, 1'b0);
        run_phase(3, 3, 1'b1, 1'b0);
        run_phase(4, 3, 1'b1, 1'b1);
        run_phase(5, 5, 1'b1, 1'b0);
        run_phase(6, 3, 1'b0, 1'b0);
        run_phase(7, 9, 1'b1, 1'b0);
        run_phase(0, 255, 1'b1, 1'b0);
        run_phase(15, 0, 1'b1, 1'b0);
        run_phase(8, 255, 1'b1, 1'b0);
        run_phase($urandom_range(0, 15), $urandom_range(0, 255), 1'b1, 1'b0);
        run_phase($urandom_range(0, 15), $urandom_range(0, 255), 1'b1, 1'b0);
        // Closing stretch without idling on either side
        run_phase(8, 29, 1'b0, 1'b0);

        settle();
        if (scoreboard.failures == 0)
            $display("galois_field_arithmetic_unit test passed");
        else
            $display("galois_field_arithmetic_unit test failed");
        $finish;
    end

endmodule
